@@ src/lhp3_pkg.sv @@
// lhp3_pkg: shared types, constants and the per-channel filter function
// of the 3x3 laplacian high-pass block; no dependencies
`timescale 1ns / 1ps

package lhp3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_DIM       = 3;

  localparam int CH_W      = 8;
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 13;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 10;
  localparam int OUT_ROW_W = 12;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [IMG_W_W-1:0] WIDTH_RST  = IMG_W_W'(512);
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = IMG_H_W'(512);

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [3*CH_W-1:0] rgb_t;

  // eight neighbours minus eight times the centre, clamped to 0..255
  function automatic logic [CH_W-1:0] lap_chan(input logic [7:0][CH_W-1:0] nbr,
                                               input logic [CH_W-1:0] ctr);
    logic [CH_W+2:0]        sum;
    logic signed [CH_W+4:0] diff;
    logic [CH_W-1:0]        res;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, nbr[i]};
    end
    diff = signed'({2'b00, sum}) - signed'({2'b00, ctr, 3'b000});
    if (diff < 0) begin
      res = '0;
    end else if (diff > 13'sd255) begin
      res = '1;
    end else begin
      res = diff[CH_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ src/lhp3_ifs.sv @@
// lhp3_ifs: valid/ready channel interfaces for pixel input and filtered result
// depends on lhp3_pkg
`timescale 1ns / 1ps

interface lhp3_pix_if;
  import lhp3_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] pixel_red;
  logic [CH_W-1:0] pixel_green;
  logic [CH_W-1:0] pixel_blue;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface lhp3_res_if;
  import lhp3_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;
  logic [OUT_COL_W-1:0] out_column;
  logic [OUT_ROW_W-1:0] out_row;
  logic                 frame_last;

  modport source (output valid, out_red, out_green, out_blue, out_column, out_row,
                  frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_column, out_row,
                  frame_last, output ready);
endinterface

@@ src/laplacian_highpass_3x3_rgb.sv @@
// laplacian_highpass_3x3_rgb: 8-neighbour laplacian high-pass on a raster RGB stream
// two line memories, a 3x3 window and a result register
// depends on lhp3_pkg and lhp3_ifs
//
//   port     dir  kind        contents
//   in_pix   in   valid/ready pixel_red, pixel_green, pixel_blue
//   out_res  out  valid/ready out_red/green/blue, out_column, out_row, frame_last
//   psel..   in   apb         image_width @0x0, image_height @0x4
//
// one pixel per clock sustained while results are taken; a result passes the line
// memory read, then window and filter into the result register
// the stage after the memory read stalls only while a result waits untaken
// rst_n is synchronous: counters, window, config, valids clear; line memories do not
`timescale 1ns / 1ps

module laplacian_highpass_3x3_rgb
  import lhp3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lhp3_pix_if.sink              in_pix,
  lhp3_res_if.source            out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ? $clog2(MAX_WIDTH + 1)
                                                              : IMG_W_W;

  // configuration
  logic [IMG_W_W-1:0] image_width_r;
  logic [IMG_H_W-1:0] image_height_r;
  logic               cfg_wr;
  cfg_reg_t           cfg_sel;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RST;
      image_height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_IMAGE_WIDTH:  image_width_r  <= pwdata[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= pwdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(image_width_r);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(image_height_r);
      default:          prdata = '0;
    endcase
  end

  // effective frame size
  logic [WCMP_W-1:0]  w_ext, w_eff;
  logic [IMG_H_W-1:0] h_eff;

  assign w_ext = WCMP_W'(image_width_r);

  always_comb begin
    if (w_ext < WCMP_W'(MIN_DIM)) begin
      w_eff = WCMP_W'(MIN_DIM);
    end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (image_height_r < IMG_H_W'(MIN_DIM)) begin
      h_eff = IMG_H_W'(MIN_DIM);
    end else if (image_height_r > IMG_H_W'(MAX_HEIGHT)) begin
      h_eff = IMG_H_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
  end

  // handshake and stage control
  logic in_acc, adv_a;
  logic valid_a_r, emit_a_r, last_a_r;
  logic out_valid_r;

  assign adv_a        = valid_a_r && (!emit_a_r || !out_valid_r || out_res.ready);
  assign in_pix.ready = !valid_a_r || adv_a;
  assign in_acc       = in_pix.valid && in_pix.ready;

  // raster counters
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [WCMP_W-1:0]  col_inc;
  logic [IMG_H_W-1:0] row_inc;
  logic               emit_in, last_in;

  assign col_inc = WCMP_W'(col_r) + WCMP_W'(1);
  assign row_inc = IMG_H_W'(row_r) + IMG_H_W'(1);
  assign emit_in = (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));
  assign last_in = (col_inc == w_eff) && (row_inc == h_eff);

  always_comb begin
    col_nxt = col_inc[COL_W-1:0];
    row_nxt = row_r;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      if (row_inc >= h_eff) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_inc[ROW_W-1:0];
      end
    end else if (IMG_H_W'(row_r) >= h_eff) begin
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line memories: read on accept, write back when the item leaves stage a
  rgb_t mem_up  [MAX_WIDTH];
  rgb_t mem_mid [MAX_WIDTH];
  rgb_t rd_up_r, rd_mid_r;
  rgb_t pix_a_r;
  logic [COL_W-1:0]     addr_a_r;
  logic [OUT_COL_W-1:0] ocol_a_r;
  logic [OUT_ROW_W-1:0] orow_a_r;
  logic [COL_W-1:0]     col_m1;

  assign col_m1 = col_r - COL_W'(1);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_up_r  <= mem_up[col_r];
      rd_mid_r <= mem_mid[col_r];
    end
    if (adv_a) begin
      mem_up[addr_a_r]  <= rd_mid_r;
      mem_mid[addr_a_r] <= pix_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (in_acc) begin
      valid_a_r <= 1'b1;
    end else if (adv_a) begin
      valid_a_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_a_r  <= {in_pix.pixel_red, in_pix.pixel_green, in_pix.pixel_blue};
      addr_a_r <= col_r;
      ocol_a_r <= OUT_COL_W'(col_m1);
      orow_a_r <= row_r - ROW_W'(1);
      emit_a_r <= emit_in;
      last_a_r <= last_in;
    end
  end

  // 3x3 window, row 0 oldest, column 0 leftmost
  rgb_t win_r   [3][3];
  rgb_t win_nxt [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = rd_up_r;
    win_nxt[1][2] = rd_mid_r;
    win_nxt[2][2] = pix_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (adv_a) begin
      win_r <= win_nxt;
    end
  end

  // per-channel filter on the updated window, k = 2 red, 1 green, 0 blue
  logic [2:0][CH_W-1:0]      flt;
  logic [2:0][7:0][CH_W-1:0] nbr;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nbr[k][0] = win_nxt[0][0][CH_W*k +: CH_W];
      nbr[k][1] = win_nxt[0][1][CH_W*k +: CH_W];
      nbr[k][2] = win_nxt[0][2][CH_W*k +: CH_W];
      nbr[k][3] = win_nxt[1][0][CH_W*k +: CH_W];
      nbr[k][4] = win_nxt[1][2][CH_W*k +: CH_W];
      nbr[k][5] = win_nxt[2][0][CH_W*k +: CH_W];
      nbr[k][6] = win_nxt[2][1][CH_W*k +: CH_W];
      nbr[k][7] = win_nxt[2][2][CH_W*k +: CH_W];
      flt[k]    = lap_chan(nbr[k], win_nxt[1][1][CH_W*k +: CH_W]);
    end
  end

  // result register
  logic [CH_W-1:0]      red_r, green_r, blue_r;
  logic [OUT_COL_W-1:0] ocol_r;
  logic [OUT_ROW_W-1:0] orow_r;
  logic                 last_r;
  logic                 load_out;

  assign load_out = adv_a && emit_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      red_r   <= flt[2];
      green_r <= flt[1];
      blue_r  <= flt[0];
      ocol_r  <= ocol_a_r;
      orow_r  <= orow_a_r;
      last_r  <= last_a_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.out_red    = red_r;
  assign out_res.out_green  = green_r;
  assign out_res.out_blue   = blue_r;
  assign out_res.out_column = ocol_r;
  assign out_res.out_row    = orow_r;
  assign out_res.frame_last = last_r;

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (valid_a_r && emit_a_r && out_valid_r && !out_res.ready))
    else $error("input stalled without a waiting result");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(valid_a_r && emit_a_r))
    else $error("result appeared without an emitting item in stage a");

  a_out_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (orow_r != '0))
    else $error("result row on the border");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> (out_valid_r && $stable(ocol_r) && $stable(red_r)))
    else $error("waiting result changed");

endmodule
